// ===== rtl/tkv_pkg.sv =====
// Shared types and constants for the top-k value tracker.
`default_nettype none
package tkv_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int KLIM_W   = 7;

	localparam logic [1:0] FUNC_UPDATE = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_READ   = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic [31:0]        item_handle;
		logic signed [15:0] item_value;
	} item_t;

	typedef struct packed {
		logic [31:0]        out_handle;
		logic signed [15:0] out_value;
		logic               last_entry;
		logic               list_empty;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} emit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COPY,
		ST_READ,
		ST_EMPTY
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/tkv_engine.sv =====
// List memory and sequencer: scan, copy-with-edit and read passes over the sorted list.
`default_nettype none
module tkv_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  tkv_pkg::item_t            cmd,
	input  logic [tkv_pkg::CNT_W-1:0] lim,
	output logic                      busy,
	output tkv_pkg::emit_t            emit,
	input  logic                      emit_ready
);
	import tkv_pkg::*;

	localparam int ADDR_W = IDX_W + 1;

	typedef struct packed {
		logic [31:0]        handle;
		logic signed [15:0] value;
	} entry_t;

	state_t state_q, state_d;

	entry_t             mem_q [2**ADDR_W];
	entry_t             rdata_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               dv_s1;
	item_t              cmd_q;
	logic               bank_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   wr_idx_q;
	logic               found_q;
	logic               min_vld_q;
	logic signed [15:0] min_q;
	logic               hit_pend_q;
	logic               ins_pend_q;
	logic               evict_pend_q;

	logic             more, drained, issue, consume;
	logic             drop_hit, drop_evict, put_new;
	logic [CNT_W-1:0] cnt_after;
	logic             not_full, take;
	logic             wr_en;
	entry_t           wr_data;
	entry_t           new_entry;
	logic             streaming;

	assign new_entry = '{handle: cmd_q.item_handle, value: cmd_q.item_value};
	assign more      = rd_ptr_q < count_q;
	assign drained   = !more && !dv_s1;
	assign streaming = (state_q == ST_SCAN) || (state_q == ST_COPY) || (state_q == ST_READ);

	// Shared compare unit: handle match and value order on the word in flight.
	assign drop_hit   = dv_s1 && hit_pend_q && (rdata_s1.handle == cmd_q.item_handle);
	assign drop_evict = dv_s1 && !drop_hit && evict_pend_q;
	assign put_new    = (state_q == ST_COPY) && dv_s1 && !drop_hit && !drop_evict
		&& ins_pend_q && (rdata_s1.value >= cmd_q.item_value);

	assign cnt_after = count_q - CNT_W'(found_q);
	assign not_full  = cnt_after < lim;
	assign take      = not_full || ((cnt_after != '0) && (min_q < cmd_q.item_value));

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		unique case (state_q)
			ST_SCAN: consume = dv_s1;
			ST_COPY: consume = dv_s1 && !put_new;
			ST_READ: consume = dv_s1 && emit_ready;
			default: consume = 1'b0;
		endcase
		issue = streaming && more && (!dv_s1 || consume);
	end

	// Write port into the spare bank during the copy pass.
	always_comb begin
		wr_en   = 1'b0;
		wr_data = new_entry;
		if (state_q == ST_COPY) begin
			if (put_new) begin
				wr_en = 1'b1;
			end else if (consume && !drop_hit && !drop_evict) begin
				wr_en   = 1'b1;
				wr_data = rdata_s1;
			end else if (drained && ins_pend_q) begin
				wr_en = 1'b1;
			end
		end
	end

	always_comb begin
		emit.valid = ((state_q == ST_READ) && dv_s1) || (state_q == ST_EMPTY);
		if (state_q == ST_EMPTY) begin
			emit.res = '{out_handle: '0, out_value: '0, last_entry: 1'b0, list_empty: 1'b1};
		end else begin
			emit.res.out_handle = rdata_s1.handle;
			emit.res.out_value  = rdata_s1.value;
			emit.res.last_entry = (CNT_W'(idx_s1) == count_q - CNT_W'(1));
			emit.res.list_empty = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd.func)
						FUNC_UPDATE: state_d = ST_SCAN;
						FUNC_REMOVE: state_d = ST_COPY;
						FUNC_READ:   state_d = (count_q == '0) ? ST_EMPTY : ST_READ;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (drained) state_d = (take || found_q) ? ST_COPY : ST_IDLE;
			end
			ST_COPY: begin
				if (drained) state_d = ST_IDLE;
			end
			ST_READ: begin
				if (drained) state_d = ST_IDLE;
			end
			ST_EMPTY: begin
				if (emit_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q       <= 1'b0;
			count_q      <= '0;
			rd_ptr_q     <= '0;
			wr_idx_q     <= '0;
			dv_s1        <= 1'b0;
			found_q      <= 1'b0;
			min_vld_q    <= 1'b0;
			hit_pend_q   <= 1'b0;
			ins_pend_q   <= 1'b0;
			evict_pend_q <= 1'b0;
		end else begin
			if (issue)        dv_s1 <= 1'b1;
			else if (consume) dv_s1 <= 1'b0;
			if (issue) rd_ptr_q <= rd_ptr_q + CNT_W'(1);
			if (wr_en) wr_idx_q <= wr_idx_q + CNT_W'(1);

			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						rd_ptr_q     <= '0;
						wr_idx_q     <= '0;
						found_q      <= 1'b0;
						min_vld_q    <= 1'b0;
						hit_pend_q   <= 1'b1;
						ins_pend_q   <= 1'b0;
						evict_pend_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (drop_hit) begin
						found_q    <= 1'b1;
						hit_pend_q <= 1'b0;
					end else if (consume && !min_vld_q) begin
						min_vld_q <= 1'b1;
					end
					if (drained) begin
						rd_ptr_q     <= '0;
						wr_idx_q     <= '0;
						hit_pend_q   <= 1'b1;
						ins_pend_q   <= take;
						evict_pend_q <= take && !not_full;
					end
				end
				ST_COPY: begin
					if (drop_hit)   hit_pend_q   <= 1'b0;
					if (drop_evict) evict_pend_q <= 1'b0;
					if (put_new)    ins_pend_q   <= 1'b0;
					if (drained) begin
						// Swap banks: the edited copy becomes the live list.
						bank_q  <= !bank_q;
						count_q <= wr_idx_q + CNT_W'(ins_pend_q);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) cmd_q <= cmd;
		if (state_q == ST_SCAN && consume && !drop_hit && !min_vld_q) min_q <= rdata_s1.value;
		if (issue) idx_s1 <= rd_ptr_q[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[{!bank_q, wr_idx_q[IDX_W-1:0]}] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (issue) rdata_s1 <= mem_q[{bank_q, rd_ptr_q[IDX_W-1:0]}];
	end

endmodule
`default_nettype wire

// ===== rtl/top_k_value_tracker_top.sv =====
// Top level of the top-k value tracker: ports, limit register and result register.
//
// Keeps up to k_limit (handle, value) pairs, k_limit clamped to 1..CAPACITY, sorted
// by ascending value in a two-bank list memory with one read and one write port; a
// lowered limit does not trim a longer list. An update takes a scan pass to find the
// handle and the smallest kept value. Unless the update leaves the list as it is, a
// copy pass follows that writes the edited list into the other bank. The copy pass
// stalls its read stream while the new pair is written when it lands inside the list
// rather than at its end. A remove takes one copy pass. A read gives one word per
// cycle while the result side does not stall, or a single empty-marked word for an
// empty list. The item side stalls for the whole operation; a finished result word
// may still wait in the output register while the next item is taken.
// The list memory needs no clearing after reset: the entry count bounds every read.
`default_nettype none
module top_k_value_tracker_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  tkv_pkg::item_t             item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output tkv_pkg::result_t           result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tkv_pkg::KLIM_W-1:0] cfg_data
);
	import tkv_pkg::*;

	logic [KLIM_W-1:0] k_limit_q;
	logic [CNT_W-1:0]  lim;
	logic              busy;
	logic              start;
	emit_t             emit;
	logic              emit_ready;
	logic              result_valid_q;
	result_t           result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                    k_limit_q <= KLIM_W'(CAPACITY);
		else if (cfg_valid && cfg_ready) k_limit_q <= cfg_data;
	end

	// Clamp the limit to 1..CAPACITY.
	always_comb begin
		if (k_limit_q == '0)                       lim = CNT_W'(1);
		else if (k_limit_q > KLIM_W'(CAPACITY))    lim = CNT_W'(CAPACITY);
		else                                       lim = CNT_W'(k_limit_q);
	end

	assign item_stall = busy;
	assign start      = item_valid && !busy;

	tkv_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (item),
		.lim        (lim),
		.busy       (busy),
		.emit       (emit),
		.emit_ready (emit_ready)
	);

	assign emit_ready = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                       result_valid_q <= 1'b0;
		else if (emit.valid && emit_ready) result_valid_q <= 1'b1;
		else if (!result_stall)            result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit.valid && emit_ready) result_q <= emit.res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

// ===== rtl/tkv_checker.sv =====
// Port-level checks for the top-k value tracker, bound to the top level.
`default_nettype none
module tkv_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_stall,
	input tkv_pkg::item_t             item,
	input logic                       result_valid,
	input logic                       result_stall,
	input tkv_pkg::result_t           result,
	input logic                       cfg_valid,
	input logic                       cfg_ready,
	input logic [tkv_pkg::KLIM_W-1:0] cfg_data
);
	import tkv_pkg::*;

	logic unused_ok;
	assign unused_ok = cfg_valid ^ cfg_ready ^ (^cfg_data) ^ (^item.item_value);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.list_empty |->
			result.out_handle == '0 && result.out_value == '0 && !result.last_entry)
		else $error("empty-marked word carries data");

	a_edit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.func == FUNC_UPDATE || item.func == FUNC_REMOVE)
			|=> item_stall)
		else $error("list edit did not occupy the block");

	a_unused_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.func != FUNC_UPDATE && item.func != FUNC_REMOVE
			&& item.func != FUNC_READ |=> !item_stall)
		else $error("unused function code left the block busy");

endmodule

bind top_k_value_tracker_top tkv_checker u_tkv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.cfg_data     (cfg_data)
);
`default_nettype wire

// ===== dv/tb_top_k_value_tracker_top.sv =====
// Self-checking testbench for the top-k value tracker: directed and random traffic.
`default_nettype none
module tb_top_k_value_tracker_top;
	import tkv_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 1500;
	localparam int POOL_SIZE      = 80;

	// Ranked list kept beside the block: ascending values, same eviction rules.
	class ranked_list;
		logic [31:0]        handles[$];
		logic signed [15:0] values[$];
		result_t            due_words[$];
		int                 limit;
		int                 mismatches;

		function new();
			limit = CAPACITY;
			mismatches = 0;
		endfunction

		function void set_limit(logic [KLIM_W-1:0] k);
			if (k == 0) limit = 1;
			else if (k > CAPACITY) limit = CAPACITY;
			else limit = int'(k);
		endfunction

		function int waiting();
			return due_words.size();
		endfunction

		function void drop_handle(logic [31:0] h);
			for (int i = 0; i < handles.size(); i++) begin
				if (handles[i] == h) begin
					handles.delete(i);
					values.delete(i);
					return;
				end
			end
		endfunction

		// New pair goes before entries of equal value.
		function void insert_sorted(logic [31:0] h, logic signed [15:0] v);
			int pos;
			pos = 0;
			while (pos < values.size() && values[pos] < v) pos++;
			handles.insert(pos, h);
			values.insert(pos, v);
		endfunction

		function void take_item(item_t it);
			result_t w;
			case (it.func)
				FUNC_UPDATE: begin
					drop_handle(it.item_handle);
					if (handles.size() < limit) begin
						insert_sorted(it.item_handle, it.item_value);
					end else if (handles.size() > 0 && values[0] < it.item_value) begin
						void'(handles.pop_front());
						void'(values.pop_front());
						insert_sorted(it.item_handle, it.item_value);
					end
				end
				FUNC_REMOVE: drop_handle(it.item_handle);
				FUNC_READ: begin
					if (handles.size() == 0) begin
						w = '0;
						w.list_empty = 1'b1;
						due_words.insert(due_words.size(), w);
					end else begin
						for (int i = 0; i < handles.size(); i++) begin
							w.out_handle = handles[i];
							w.out_value  = values[i];
							w.last_entry = (i == handles.size() - 1);
							w.list_empty = 1'b0;
							due_words.insert(due_words.size(), w);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (due_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: handle=%h value=%0d last=%b empty=%b",
						got.out_handle, got.out_value, got.last_entry, got.list_empty);
				return;
			end
			want = due_words.pop_front();
			if (got.out_handle !== want.out_handle || got.out_value !== want.out_value ||
					got.last_entry !== want.last_entry ||
					got.list_empty !== want.list_empty) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("word mismatch: expected handle=%h value=%0d last=%b empty=%b",
						want.out_handle, want.out_value, want.last_entry, want.list_empty);
					$display("               got      handle=%h value=%0d last=%b empty=%b",
						got.out_handle, got.out_value, got.last_entry, got.list_empty);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	item_t              item_word = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_t            result_word;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [KLIM_W-1:0]  cfg_data = '0;

	ranked_list  book;
	bit          quiet = 1'b0;
	logic [31:0] handle_pool[POOL_SIZE];
	int          stall_left = 0;
	int          calm_left = 0;
	int          idle_cycles = 0;

	top_k_value_tracker_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_word),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: random stall bursts mixed with calm stretches.
	always @(posedge clk) begin
		if (quiet || !arst_n) begin
			result_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (calm_left != 0) begin
			calm_left <= calm_left - 1;
			result_stall <= 1'b0;
		end else begin
			case ($urandom_range(0, 2))
				0: begin
					stall_left <= $urandom_range(0, 12);
					result_stall <= 1'b1;
				end
				1: begin
					calm_left <= $urandom_range(10, 60);
					result_stall <= 1'b0;
				end
				default: result_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			book.check_word(result_word);
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("** top_k_value_tracker_top: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic item_t op_item(logic [1:0] f, logic [31:0] h, logic signed [15:0] v);
		item_t it;
		it.func = f;
		it.item_handle = h;
		it.item_value = v;
		return it;
	endfunction

	function automatic item_t random_item(int upd_pct, int pool_n);
		item_t it;
		int r;
		r = $urandom_range(0, 99);
		if (r < upd_pct) begin
			it.func = FUNC_UPDATE;
		end else begin
			r = $urandom_range(0, 9);
			it.func = (r < 4) ? FUNC_REMOVE : (r < 9) ? FUNC_READ : FUNC_UNUSED;
		end
		if ($urandom_range(0, 6) == 0)
			it.item_handle = $urandom;
		else
			it.item_handle = handle_pool[$urandom_range(0, pool_n - 1)];
		case ($urandom_range(0, 4))
			0, 1: it.item_value = 16'($urandom_range(0, 8) - 4);
			2: it.item_value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: it.item_value = 16'($urandom);
		endcase
		return it;
	endfunction

	// Leaves valid high after acceptance so back-to-back words need no gap.
	task automatic send_item(input item_t it);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item_word <= it;
		do @(posedge clk); while (item_stall);
		book.take_item(it);
	endtask

	// Drain all reads and let a trailing update finish before touching the limit.
	task automatic write_limit(input logic [KLIM_W-1:0] k);
		item_valid <= 1'b0;
		while (book.waiting() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= k;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		book.set_limit(k);
	endtask

	task automatic run_random(input int count, input int upd_pct, input int pool_n);
		repeat (count) send_item(random_item(upd_pct, pool_n));
	endtask

	initial begin
		book = new();
		handle_pool[0] = 32'h0000_0000;
		handle_pool[1] = 32'hffff_ffff;
		for (int i = 2; i < POOL_SIZE; i++) handle_pool[i] = $urandom;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list, extremes, equal values, re-value, removes, unused code.
		send_item(op_item(FUNC_READ, 32'h0, 16'sh0));
		send_item(op_item(FUNC_UPDATE, 32'h0000_0000, 16'sh8000));
		send_item(op_item(FUNC_UPDATE, 32'hffff_ffff, 16'sh7fff));
		send_item(op_item(FUNC_UPDATE, 32'd5, 16'sh0));
		send_item(op_item(FUNC_UPDATE, 32'd6, 16'sh0));
		send_item(op_item(FUNC_READ, 32'h0, 16'sh0));
		send_item(op_item(FUNC_UPDATE, 32'd5, 16'sd100));
		send_item(op_item(FUNC_REMOVE, 32'd6, 16'sh0));
		send_item(op_item(FUNC_REMOVE, 32'd77, 16'sh0));
		send_item(op_item(FUNC_UNUSED, 32'd5, -16'sd1));
		send_item(op_item(FUNC_READ, 32'h0, 16'sh0));

		// Limit lowered below the count: equal value rejected, one eviction only.
		write_limit(7'd2);
		send_item(op_item(FUNC_UPDATE, 32'd9, 16'sh8000));
		send_item(op_item(FUNC_UPDATE, 32'd10, 16'sd50));
		send_item(op_item(FUNC_READ, 32'h0, 16'sh0));
		send_item(op_item(FUNC_UPDATE, 32'd5, -16'sd5));
		send_item(op_item(FUNC_READ, 32'h0, 16'sh0));

		// Zero limit acts as one.
		write_limit(7'd0);
		send_item(op_item(FUNC_UPDATE, 32'd3, 16'sd1));
		send_item(op_item(FUNC_UPDATE, 32'd4, 16'sh7fff));
		send_item(op_item(FUNC_READ, 32'h0, 16'sh0));
		send_item(op_item(FUNC_REMOVE, 32'hffff_ffff, 16'sh0));
		send_item(op_item(FUNC_READ, 32'h0, 16'sh0));

		write_limit(7'd127);
		run_random(20, 70, 20);
		write_limit(7'd64);
		run_random(100, 85, POOL_SIZE);
		write_limit(7'd3);
		run_random(40, 60, 10);
		write_limit(7'd1);
		run_random(25, 60, 10);
		write_limit(7'd0);
		run_random(15, 60, 10);
		write_limit(7'($urandom_range(2, 63)));
		run_random(45, 65, 40);

		write_limit(7'd127);
		quiet = 1'b1;
		run_random(50, 70, POOL_SIZE);

		item_valid <= 1'b0;
		while (book.waiting() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.mismatches == 0 && book.waiting() == 0)
			$display("** top_k_value_tracker_top: PASSED **");
		else
			$display("** top_k_value_tracker_top: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
